@@ rtl/lirs_pkg.sv @@
// lirs_pkg: shared widths, register indexes, reset values and divider job codes
// for the linear interpolation resampler
// depends on nothing
package lirs_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RATE_W     = 18;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    localparam int CNT_W      = 7;
    localparam logic [CNT_W-1:0] RESULT_CAP = 7'd64;

    localparam int PROD_W     = 36;
    localparam int NUM_W      = 38;
    localparam int DVSR_W     = 19;
    localparam int REM_W      = 20;
    localparam int INTERP_QB  = 17;
    localparam int STEP_QB    = 19;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STREAM_LENGTH = 2'd2;

    localparam logic [RATE_W-1:0]     SOURCE_RESET = 18'd16000;
    localparam logic [RATE_W-1:0]     TARGET_RESET = 18'd48000;
    localparam logic [CFG_DATA_W-1:0] LENGTH_RESET = 24'd1;

    typedef enum logic [1:0] {
        DK_TOTAL  = 2'd0,
        DK_INTERP = 2'd1,
        DK_STEP   = 2'd2
    } t_div_kind;

endpackage

@@ rtl/linear_interp_resampler.sv @@
// linear_interp_resampler: linear interpolation sample rate converter with one
// shared restoring divider under a one-hot sequencer
// depends on lirs_pkg
//
// channel  dir  handshake                  payload
// in       in   i_in_valid / o_in_ready    i_sample_in
// out      out  o_out_valid / i_out_ready  o_sample_out, o_last_out
// cfg      in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one input beat at a time; pass-through goes from idle to the emit step, then to fin and back to idle
// interpolated output: multiply, numerator, divider load, the 17 divider steps, then emit;
// the phase step adds the full 19-step divide when phase plus source reaches twice the target (downsampling)
// first input of a buffer adds the output count divide (length times target, divided by source)
// synchronous active-low reset; a stalled output holds the sequencer in its emit step
module linear_interp_resampler #(
    parameter int MAX_UP      = 32,
    parameter int LENGTH_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [lirs_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [lirs_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                 o_last_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lirs_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lirs_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int LB  = LENGTH_BITS;
    localparam int UPW = $clog2(MAX_UP + 1);
    localparam int TW  = LB + UPW;
    localparam int QW  = LB + lirs_pkg::RATE_W;
    localparam int CW  = $clog2(QW + 1);
    localparam int MW  = lirs_pkg::RATE_W + UPW;
    localparam int AW  = (LB > lirs_pkg::STEP_QB) ? LB : lirs_pkg::STEP_QB;
    localparam int SW  = lirs_pkg::SAMPLE_W;
    localparam int RW  = lirs_pkg::RATE_W;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_TMUL  = 13'b0000000000010,
        S_CHECK = 13'b0000000000100,
        S_MUL   = 13'b0000000001000,
        S_NUM   = 13'b0000000010000,
        S_DLOAD = 13'b0000000100000,
        S_DIV   = 13'b0000001000000,
        S_TFIX  = 13'b0000010000000,
        S_IFIN  = 13'b0000100000000,
        S_EMIT  = 13'b0001000000000,
        S_ADV   = 13'b0010000000000,
        S_AFIN  = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } t_state;

    t_state                          r_state;
    logic [RW-1:0]                   r_source;
    logic [RW-1:0]                   r_target;
    logic [lirs_pkg::CFG_DATA_W-1:0] r_length;

    logic signed [SW-1:0]            r_prev;
    logic [LB-1:0]                   r_k;
    logic [TW-1:0]                   r_sent;
    logic [LB-1:0]                   r_nli;
    logic [RW-1:0]                   r_phase;
    logic [TW-1:0]                   r_total;

    logic signed [SW-1:0]            r_cur;
    logic                            r_last_in;
    logic                            r_pass;
    logic [SW-1:0]                   r_val;
    logic [lirs_pkg::CNT_W-1:0]      r_cnt;

    logic signed [lirs_pkg::PROD_W-1:0] r_prod;
    logic [lirs_pkg::NUM_W-1:0]      r_num;
    logic                            r_neg;

    logic [lirs_pkg::REM_W-1:0]      r_rem;
    logic [QW-1:0]                   r_quo;
    logic [lirs_pkg::DVSR_W-1:0]     r_dvsr;
    logic [CW-1:0]                   r_div_cnt;
    lirs_pkg::t_div_kind             r_div_kind;

    logic                            r_out_valid;
    logic [SW-1:0]                   r_out_sample;
    logic                            r_out_last;

    logic [LB-1:0]                   w_len_raw;
    logic [LB-1:0]                   w_len;
    logic                            w_last_in;
    logic [MW-1:0]                   w_up_lim;
    logic                            w_pass;
    logic [QW-1:0]                   w_len_t;
    logic [lirs_pkg::DVSR_W-1:0]     w_two_t;
    logic [LB:0]                     w_nli1;
    logic [LB:0]                     w_k1;
    logic signed [SW:0]              w_diff;
    logic signed [lirs_pkg::PROD_W-1:0] w_prod;
    logic [lirs_pkg::NUM_W-1:0]      w_num;
    logic [lirs_pkg::NUM_W-1:0]      w_m;
    logic [lirs_pkg::REM_W-1:0]      w_rem_sh;
    logic                            w_ge;
    logic [lirs_pkg::REM_W-1:0]      w_rem_sub;
    logic [lirs_pkg::INTERP_QB:0]    w_q17;
    logic [SW+1:0]                   w_interp;
    logic [lirs_pkg::DVSR_W-1:0]     w_acc;
    logic [lirs_pkg::DVSR_W-1:0]     w_acc_sub;
    logic                            w_acc_ge_t;
    logic [AW-1:0]                   w_nli_sum;
    logic                            w_in_acc;
    logic                            w_cfg_acc;
    logic                            w_out_free;
    logic                            w_out_load;

    assign o_in_ready   = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready  = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_sample;
    assign o_last_out   = r_out_last;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = (r_state == S_EMIT) && (r_cnt != lirs_pkg::RESULT_CAP) && w_out_free;

    // zero length acts as one
    assign w_len_raw = LB'(r_length);
    assign w_len     = (w_len_raw == '0) ? LB'(1) : w_len_raw;
    assign w_last_in = (r_k >= (w_len - LB'(1)));

    assign w_up_lim = MW'(r_source) * MW'(MAX_UP);
    assign w_pass   = (r_source == '0) || (r_target == '0) || (r_source == r_target) ||
                      (MW'(r_target) > w_up_lim);

    assign w_len_t = QW'(w_len) * QW'(r_target);
    assign w_two_t = {r_target, 1'b0};
    assign w_nli1  = {1'b0, r_nli} + (LB + 1)'(1);
    assign w_k1    = {1'b0, r_k};

    // interpolation numerator 2*(b-a)*phase + t
    assign w_diff = {r_cur[SW-1], r_cur} - {r_prev[SW-1], r_prev};
    assign w_prod = (lirs_pkg::PROD_W)'(w_diff) *
                    (lirs_pkg::PROD_W)'($signed({1'b0, r_phase}));
    assign w_num  = {r_prod[lirs_pkg::PROD_W-1], r_prod, 1'b0} +
                    {{(lirs_pkg::NUM_W - RW){1'b0}}, r_target};
    // floor division of a negative numerator: divide (d-1)-n = ~n + d, then negate
    assign w_m    = r_num[lirs_pkg::NUM_W-1] ?
                    (~r_num + {{(lirs_pkg::NUM_W - lirs_pkg::DVSR_W){1'b0}}, w_two_t}) :
                    r_num;

    // restoring divider step
    assign w_rem_sh  = {r_rem[lirs_pkg::REM_W-2:0], r_quo[QW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_dvsr});
    assign w_rem_sub = w_rem_sh - {1'b0, r_dvsr};

    assign w_q17    = {1'b0, r_quo[lirs_pkg::INTERP_QB-1:0]};
    assign w_interp = {{2{r_prev[SW-1]}}, r_prev} +
                      (r_neg ? (SW + 2)'(-w_q17) : (SW + 2)'(w_q17));

    // phase step
    assign w_acc      = {1'b0, r_phase} + {1'b0, r_source};
    assign w_acc_ge_t = (w_acc >= {1'b0, r_target});
    assign w_acc_sub  = w_acc - {1'b0, r_target};
    assign w_nli_sum  = AW'(r_nli) + AW'(r_quo[lirs_pkg::STEP_QB-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_source    <= lirs_pkg::SOURCE_RESET;
            r_target    <= lirs_pkg::TARGET_RESET;
            r_length    <= lirs_pkg::LENGTH_RESET;
            r_prev      <= '0;
            r_k         <= '0;
            r_sent      <= '0;
            r_nli       <= '0;
            r_phase     <= '0;
            r_total     <= '0;
            r_cnt       <= '0;
            r_div_cnt   <= '0;
            r_div_kind  <= lirs_pkg::DK_TOTAL;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_cfg_acc) begin
                        case (i_cfg_index)
                            lirs_pkg::REG_SOURCE_RATE: r_source <= i_cfg_data[RW-1:0];
                            lirs_pkg::REG_TARGET_RATE: r_target <= i_cfg_data[RW-1:0];
                            lirs_pkg::REG_STREAM_LENGTH: r_length <= i_cfg_data;
                            default: ;
                        endcase
                        if (i_cfg_index == lirs_pkg::REG_SOURCE_RATE ||
                            i_cfg_index == lirs_pkg::REG_TARGET_RATE ||
                            i_cfg_index == lirs_pkg::REG_STREAM_LENGTH) begin
                            r_prev  <= '0;
                            r_k     <= '0;
                            r_sent  <= '0;
                            r_nli   <= '0;
                            r_phase <= '0;
                        end
                    end else if (w_in_acc) begin
                        r_cur     <= i_sample_in;
                        r_last_in <= w_last_in;
                        r_pass    <= w_pass;
                        r_cnt     <= '0;
                        if (w_pass) begin
                            r_val   <= i_sample_in;
                            r_state <= S_EMIT;
                        end else if (r_k == '0) begin
                            r_state <= S_TMUL;
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_TMUL: begin
                    r_quo      <= w_len_t;
                    r_rem      <= '0;
                    r_dvsr     <= {1'b0, r_source};
                    r_div_cnt  <= CW'(QW);
                    r_div_kind <= lirs_pkg::DK_TOTAL;
                    r_state    <= S_DIV;
                end
                S_TFIX: begin
                    r_total <= (r_quo == '0) ? TW'(1) : r_quo[TW-1:0];
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_sent >= r_total) begin
                        r_state <= S_FIN;
                    end else if (w_nli1 == w_k1) begin
                        r_state <= S_MUL;
                    end else if (r_last_in && (w_nli1 > w_k1)) begin
                        r_val   <= r_cur;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_num   <= w_num;
                    r_state <= S_DLOAD;
                end
                S_DLOAD: begin
                    r_neg      <= r_num[lirs_pkg::NUM_W-1];
                    r_rem      <= w_m[lirs_pkg::INTERP_QB + lirs_pkg::REM_W - 1:
                                      lirs_pkg::INTERP_QB];
                    r_quo      <= {w_m[lirs_pkg::INTERP_QB-1:0],
                                   {(QW - lirs_pkg::INTERP_QB){1'b0}}};
                    r_dvsr     <= w_two_t;
                    r_div_cnt  <= CW'(lirs_pkg::INTERP_QB);
                    r_div_kind <= lirs_pkg::DK_INTERP;
                    r_state    <= S_DIV;
                end
                S_DIV: begin
                    r_rem     <= w_ge ? w_rem_sub : w_rem_sh;
                    r_quo     <= {r_quo[QW-2:0], w_ge};
                    r_div_cnt <= r_div_cnt - CW'(1);
                    if (r_div_cnt == CW'(1)) begin
                        case (r_div_kind)
                            lirs_pkg::DK_TOTAL:  r_state <= S_TFIX;
                            lirs_pkg::DK_INTERP: r_state <= S_IFIN;
                            lirs_pkg::DK_STEP:   r_state <= S_AFIN;
                            default:             r_state <= S_FIN;
                        endcase
                    end
                end
                S_IFIN: begin
                    r_val   <= w_interp[SW-1:0];
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_cnt == lirs_pkg::RESULT_CAP) begin
                        r_state <= r_pass ? S_FIN : S_ADV;
                    end else if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_val;
                        r_out_last   <= r_pass ? r_last_in : ((r_sent + TW'(1)) == r_total);
                        r_cnt        <= r_cnt + lirs_pkg::CNT_W'(1);
                        r_state      <= r_pass ? S_FIN : S_ADV;
                    end
                end
                S_ADV: begin
                    r_sent <= r_sent + TW'(1);
                    if (w_acc < w_two_t) begin
                        if (w_acc_ge_t) begin
                            r_nli   <= r_nli + LB'(1);
                            r_phase <= w_acc_sub[RW-1:0];
                        end else begin
                            r_phase <= w_acc[RW-1:0];
                        end
                        r_state <= S_CHECK;
                    end else begin
                        r_rem      <= '0;
                        r_quo      <= {w_acc, {(QW - lirs_pkg::STEP_QB){1'b0}}};
                        r_dvsr     <= {1'b0, r_target};
                        r_div_cnt  <= CW'(lirs_pkg::STEP_QB);
                        r_div_kind <= lirs_pkg::DK_STEP;
                        r_state    <= S_DIV;
                    end
                end
                S_AFIN: begin
                    r_nli   <= w_nli_sum[LB-1:0];
                    r_phase <= r_rem[RW-1:0];
                    r_state <= S_CHECK;
                end
                S_FIN: begin
                    if (r_last_in) begin
                        r_prev  <= '0;
                        r_k     <= '0;
                        r_sent  <= '0;
                        r_nli   <= '0;
                        r_phase <= '0;
                    end else begin
                        r_prev <= r_cur;
                        r_k    <= r_k + LB'(1);
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // phase numerator stays below the target rate between beats
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_target != '0) |-> (r_phase < r_target))
        else $error("phase out of range");

    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= lirs_pkg::RESULT_CAP)
        else $error("result count above cap");

    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div_cnt != '0))
        else $error("divider running with zero step count");

    a_sent_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_sent <= r_total))
        else $error("more outputs sent than the buffer yields");

    a_load_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_EMIT))
        else $error("output loaded outside emit step");

endmodule
